// File: rtl/core/periodic_ghost_image_generator_top_assert.svh
// Assertion macros for the periodic ghost image generator top level.
`ifndef PERIODIC_GHOST_IMAGE_GENERATOR_TOP_ASSERT_SVH
`define PERIODIC_GHOST_IMAGE_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PGIG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgig: same-cycle check failed");
`define PGIG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgig: next-cycle check failed");
`else
`define PGIG_ASSERT_NOW(lbl, ante, cons)
`define PGIG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/pgig_pkg.sv
// Shared types, constants and emission-order tables for the ghost image generator.
package pgig_pkg;

  localparam int COORD_W  = 32;
  localparam int BOX_W    = COORD_W - 1;
  localparam int GHOST_W  = COORD_W + 1;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SKIN   = 3'd6;

  // Shifted-axis masks
  localparam logic [2:0] MASK_NONE = 3'b000;
  localparam logic [2:0] MASK_X    = 3'b001;
  localparam logic [2:0] MASK_Y    = 3'b010;
  localparam logic [2:0] MASK_Z    = 3'b100;
  localparam logic [2:0] MASK_XY   = MASK_X | MASK_Y;
  localparam logic [2:0] MASK_XZ   = MASK_X | MASK_Z;
  localparam logic [2:0] MASK_YZ   = MASK_Y | MASK_Z;
  localparam logic [2:0] MASK_XYZ  = MASK_X | MASK_Y | MASK_Z;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [GHOST_W-1:0] sh_x;
    logic signed [GHOST_W-1:0] sh_y;
    logic signed [GHOST_W-1:0] sh_z;
    logic [2:0]                flags;
  } pgig_entry_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] cnt;
  } pgig_qstat_t;

  // Number of ghosts for a set of flagged axes
  function automatic logic [2:0] ghost_count(input logic [2:0] flags);
    logic [2:0] n;
    case (flags) inside
      MASK_X, MASK_Y, MASK_Z: n = 3'd1;
      MASK_XY, MASK_XZ, MASK_YZ: n = 3'd3;
      MASK_XYZ: n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Shift mask of the k-th ghost for a set of flagged axes
  function automatic logic [2:0] ghost_mask(input logic [2:0] flags, input logic [2:0] k);
    logic [7:0][2:0] seq;
    seq = '0;
    case (flags)
      MASK_X:   seq = {MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                       MASK_NONE, MASK_NONE, MASK_NONE, MASK_X};
      MASK_XY:  seq = {MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                       MASK_NONE, MASK_Y, MASK_XY, MASK_X};
      MASK_XYZ: seq = {MASK_NONE, MASK_Z, MASK_XZ, MASK_YZ,
                       MASK_XYZ, MASK_Y, MASK_XY, MASK_X};
      MASK_XZ:  seq = {MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                       MASK_NONE, MASK_XZ, MASK_Z, MASK_X};
      MASK_Y:   seq = {MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                       MASK_NONE, MASK_NONE, MASK_NONE, MASK_Y};
      MASK_YZ:  seq = {MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                       MASK_NONE, MASK_YZ, MASK_Z, MASK_Y};
      MASK_Z:   seq = {MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                       MASK_NONE, MASK_NONE, MASK_NONE, MASK_Z};
      default:  seq = '0;
    endcase
    return seq[k];
  endfunction

endpackage

// File: rtl/core/pgig_front.sv
// Front end: configuration registers, atom intake and face classification.
module pgig_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pgig_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgig_pkg::BOX_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pgig_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [pgig_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [pgig_pkg::COORD_W-1:0]  in_pos_z,
  input  pgig_pkg::pgig_qstat_t                q_stat,
  output logic                                 q_push,
  output pgig_pkg::pgig_entry_t                q_wdata
);
  import pgig_pkg::*;

  logic [2:0]       wrap_r, wrap_nxt;
  logic [BOX_W-1:0] box_x_r, box_x_nxt;
  logic [BOX_W-1:0] box_y_r, box_y_nxt;
  logic [BOX_W-1:0] box_z_r, box_z_nxt;
  logic [BOX_W-1:0] skin_r, skin_nxt;
  logic [2:0]       flags;

  // Axis is flagged when periodic and the coordinate sits within skin of a face
  function automatic logic axis_flag(input logic wrap, input logic signed [COORD_W-1:0] r,
                                     input logic [BOX_W-1:0] box,
                                     input logic [BOX_W-1:0] skin);
    logic signed [GHOST_W-1:0] r_ext, skin_ext, box_ext, hi_sum;
    r_ext    = {r[COORD_W-1], r};
    skin_ext = {{(GHOST_W-BOX_W){1'b0}}, skin};
    box_ext  = {{(GHOST_W-BOX_W){1'b0}}, box};
    // r > box - skin, rearranged to stay in range
    hi_sum   = r_ext + skin_ext;
    return wrap && ((r_ext < skin_ext) || (hi_sum > box_ext));
  endfunction

  // +box in the lower half of the cell, -box otherwise
  function automatic logic signed [GHOST_W-1:0] axis_shift(input logic signed [COORD_W-1:0] r,
                                                           input logic [BOX_W-1:0] box);
    logic signed [GHOST_W-1:0] r2, box_ext;
    r2      = {r, 1'b0};
    box_ext = {{(GHOST_W-BOX_W){1'b0}}, box};
    return (r2 < box_ext) ? box_ext : -box_ext;
  endfunction

  // Register writes; indexes beyond the list are dropped
  always_comb begin
    wrap_nxt  = wrap_r;
    box_x_nxt = box_x_r;
    box_y_nxt = box_y_r;
    box_z_nxt = box_z_r;
    skin_nxt  = skin_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WRAP_X: wrap_nxt[0] = cfg_data[0];
        REG_WRAP_Y: wrap_nxt[1] = cfg_data[0];
        REG_WRAP_Z: wrap_nxt[2] = cfg_data[0];
        REG_BOX_X:  box_x_nxt   = cfg_data;
        REG_BOX_Y:  box_y_nxt   = cfg_data;
        REG_BOX_Z:  box_z_nxt   = cfg_data;
        REG_SKIN:   skin_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r  <= '0;
      box_x_r <= '0;
      box_y_r <= '0;
      box_z_r <= '0;
      skin_r  <= '0;
    end else begin
      wrap_r  <= wrap_nxt;
      box_x_r <= box_x_nxt;
      box_y_r <= box_y_nxt;
      box_z_r <= box_z_nxt;
      skin_r  <= skin_nxt;
    end
  end

  // Classification
  always_comb begin
    flags[0] = axis_flag(wrap_r[0], in_pos_x, box_x_r, skin_r);
    flags[1] = axis_flag(wrap_r[1], in_pos_y, box_y_r, skin_r);
    flags[2] = axis_flag(wrap_r[2], in_pos_z, box_z_r, skin_r);
  end

  always_comb begin
    q_wdata.pos_x = in_pos_x;
    q_wdata.pos_y = in_pos_y;
    q_wdata.pos_z = in_pos_z;
    q_wdata.sh_x  = axis_shift(in_pos_x, box_x_r);
    q_wdata.sh_y  = axis_shift(in_pos_y, box_y_r);
    q_wdata.sh_z  = axis_shift(in_pos_z, box_z_r);
    q_wdata.flags = flags;
  end

  // Atoms away from every face are taken and dropped
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready && (flags != MASK_NONE);

endmodule

// File: rtl/core/pgig_queue.sv
// Short FIFO of classified atoms between front and back ends.
module pgig_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pgig_pkg::pgig_entry_t wdata,
  input  logic                  pop,
  output pgig_pkg::pgig_entry_t rdata,
  output pgig_pkg::pgig_qstat_t stat
);
  import pgig_pkg::*;

  pgig_entry_t       slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = slot_r[rd_ptr_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.cnt   = cnt_r;

endmodule

// File: rtl/core/pgig_back.sv
// Back end: walks the emission order of the head atom and drives the result register.
module pgig_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  pgig_pkg::pgig_entry_t                q_rdata,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pgig_pkg::GHOST_W-1:0]  out_ghost_x,
  output logic signed [pgig_pkg::GHOST_W-1:0]  out_ghost_y,
  output logic signed [pgig_pkg::GHOST_W-1:0]  out_ghost_z,
  output logic                                 out_last_ghost
);
  import pgig_pkg::*;

  logic [2:0]                idx_r, idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [GHOST_W-1:0] gx_r, gy_r, gz_r;
  logic                      last_r;
  logic                      load;
  logic [2:0]                n_ghost;
  logic [2:0]                mask;
  logic                      is_last;
  logic signed [GHOST_W-1:0] gx, gy, gz;

  // A head atom is waiting and the result register is free or being emptied this cycle
  assign load    = q_valid && (!out_valid_r || out_ready);
  assign n_ghost = ghost_count(q_rdata.flags);
  assign mask    = ghost_mask(q_rdata.flags, idx_r);
  assign is_last = (idx_r == 3'(n_ghost - 3'd1));

  // Image coordinates
  always_comb begin
    gx = {q_rdata.pos_x[COORD_W-1], q_rdata.pos_x} + (mask[0] ? q_rdata.sh_x : GHOST_W'(0));
    gy = {q_rdata.pos_y[COORD_W-1], q_rdata.pos_y} + (mask[1] ? q_rdata.sh_y : GHOST_W'(0));
    gz = {q_rdata.pos_z[COORD_W-1], q_rdata.pos_z} + (mask[2] ? q_rdata.sh_z : GHOST_W'(0));
  end

  // Sequencer over the ghosts of the head atom
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 3'd0 : 3'(idx_r + 3'd1);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      gx_r   <= gx;
      gy_r   <= gy;
      gz_r   <= gz;
      last_r <= is_last;
    end
  end

  assign q_pop          = load && is_last;
  assign out_valid      = out_valid_r;
  assign out_ghost_x    = gx_r;
  assign out_ghost_y    = gy_r;
  assign out_ghost_z    = gz_r;
  assign out_last_ghost = last_r;

endmodule

// File: rtl/core/periodic_ghost_image_generator_top.sv
// Top level of the periodic ghost image generator.
// Takes one atom position per transaction and returns the 0 to 7 periodic
// ghost images near the cell faces, in the fixed order, with the final one
// flagged by out_last_ghost; atoms clear of every face produce nothing. The
// front end accepts an atom in every cycle in which its four-entry queue has
// room and classifies it in that cycle; the back end emits one image per
// cycle while out_ready is high, so an atom with n ghosts holds the back end
// until all n images are out; the result register sets the sustained rate.
// With an empty queue an accepted atom passes a queue slot, then the result
// register, before its first image. The user must write the registers via
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`include "periodic_ghost_image_generator_top_assert.svh"
module periodic_ghost_image_generator_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pgig_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgig_pkg::BOX_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pgig_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [pgig_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [pgig_pkg::COORD_W-1:0]  in_pos_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pgig_pkg::GHOST_W-1:0]  out_ghost_x,
  output logic signed [pgig_pkg::GHOST_W-1:0]  out_ghost_y,
  output logic signed [pgig_pkg::GHOST_W-1:0]  out_ghost_z,
  output logic                                 out_last_ghost
);
  import pgig_pkg::*;

  pgig_qstat_t q_stat;
  pgig_entry_t q_wdata;
  pgig_entry_t q_rdata;
  logic        q_push;
  logic        q_pop;

  pgig_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_pos_z  (in_pos_z),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  pgig_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  pgig_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_stat.valid),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ghost_x    (out_ghost_x),
    .out_ghost_y    (out_ghost_y),
    .out_ghost_z    (out_ghost_z),
    .out_last_ghost (out_last_ghost)
  );

  // Checks
  `PGIG_ASSERT_NOW(a_push_needs_accept, q_push, in_valid && in_ready)
  `PGIG_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.cnt <= QCNT_W'(QDEPTH))
  `PGIG_ASSERT_NEXT(a_idle_no_result, !q_stat.valid && (!out_valid || out_ready), !out_valid)
  `PGIG_ASSERT_NEXT(a_pop_on_last, q_pop, out_valid && out_last_ghost)

endmodule
